FILE: hw/rtl/ssm_pkg.sv
// Shared constants, types and the log2 fraction table of the segmental SNR meter.
`timescale 1ns / 1ps
package ssm_pkg;

   localparam int MAX_FRAME_LEN     = 4096;
   localparam int LOG_TABLE_ENTRIES = 64;

   localparam int SAMPLE_W    = 16;
   localparam int FRAME_ACC_W = 48;
   localparam int TOTAL_W     = 64;
   localparam int SEG_SUM_W   = 48;
   localparam int TALLY_W     = 32;
   localparam int THRESH_W    = 31;
   localparam int CAP_W       = 15;
   localparam int SNR_W       = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 31;
   localparam int FRAME_CNT_W = $clog2(MAX_FRAME_LEN + 1);
   localparam int LOG_IDX_W   = $clog2(LOG_TABLE_ENTRIES);
   localparam int LOG_FRAC_W  = 16;
   localparam int LOG_EXP_W   = $clog2(TOTAL_W);
   localparam int LOG_W       = LOG_EXP_W + LOG_FRAC_W;
   localparam int DB_MUL_W    = 18;
   localparam int DB_PROD_W   = LOG_W + DB_MUL_W;
   localparam int THR_PROD_W  = THRESH_W + FRAME_CNT_W;
   localparam int DIV_STEPS   = SEG_SUM_W + 1;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   localparam logic [DB_MUL_W-1:0] DB_PER_LOG2_Q16 = 18'd197283;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ENERGY_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOSSLESS_SNR_CAP = 1'b1;

   localparam logic [THRESH_W-1:0] ENERGY_THRESHOLD_RESET = 31'd50;
   localparam logic [CAP_W-1:0]    LOSSLESS_SNR_CAP_RESET = 15'd16640;

   typedef struct packed {
      logic                   finish;
      logic [FRAME_ACC_W-1:0] signal;
      logic [FRAME_ACC_W-1:0] error;
      logic [FRAME_CNT_W-1:0] count;
   } frame_rec_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_THRESH,
      B_DECIDE,
      B_LOG_S,
      B_LOG_N,
      B_MUL,
      B_ROUND,
      B_FIN_CHECK,
      B_DIV,
      B_AVG,
      B_OUT
   } back_state_type;

   typedef logic [LOG_FRAC_W-1:0] log_table_type [LOG_TABLE_ENTRIES];

   function automatic log_table_type build_log_table();
      log_table_type      t;
      logic [63:0]        x;
      logic [LOG_FRAC_W-1:0] r;
      for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
         x = (64'(LOG_TABLE_ENTRIES + i) << 30) / 64'(LOG_TABLE_ENTRIES);
         r = '0;
         for (int k = 0; k < LOG_FRAC_W; k++) begin
            x = (x * x) >> 30;
            r = {r[LOG_FRAC_W-2:0], 1'b0};
            if (x >= (64'd2 << 30)) begin
               r[0] = 1'b1;
               x = x >> 1;
            end
         end
         t[i] = r;
      end
      return t;
   endfunction

   localparam log_table_type LOG_TABLE = build_log_table();

endpackage

FILE: hw/rtl/ssm_front.sv
// Front end: squares each sample pair, accumulates frame energies, emits frame and finish records.
`timescale 1ns / 1ps
module ssm_front
   import ssm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic [SAMPLE_W-1:0] req_clean_sample,
   input  logic [SAMPLE_W-1:0] req_processed_sample,
   input  logic                req_frame_end,
   output logic                push_valid,
   output frame_rec_type       push_rec,
   input  logic                push_ready
);

   logic                   a_valid_ff;
   logic                   a_finish_ff;
   logic                   a_fe_ff;
   logic [30:0]            sq_s_ff;
   logic [31:0]            sq_e_ff;
   logic [FRAME_ACC_W-1:0] s_acc_ff;
   logic [FRAME_ACC_W-1:0] n_acc_ff;
   logic [FRAME_CNT_W-1:0] cnt_ff;

   logic signed [SAMPLE_W:0]     diff;
   logic signed [2*SAMPLE_W-1:0] cc;
   logic signed [2*SAMPLE_W+1:0] dd;
   logic [FRAME_ACC_W-1:0]       s_in;
   logic [FRAME_ACC_W-1:0]       n_in;
   logic [FRAME_CNT_W-1:0]       cnt_in;
   logic                         close;
   logic                         advance;

   assign diff = $signed({req_clean_sample[SAMPLE_W-1], req_clean_sample})
               - $signed({req_processed_sample[SAMPLE_W-1], req_processed_sample});
   assign cc = $signed(req_clean_sample) * $signed(req_clean_sample);
   assign dd = diff * diff;

   assign s_in   = s_acc_ff + FRAME_ACC_W'(sq_s_ff);
   assign n_in   = n_acc_ff + FRAME_ACC_W'(sq_e_ff);
   assign cnt_in = cnt_ff + 1'b1;
   assign close  = !a_finish_ff
                   && (a_fe_ff || cnt_in == FRAME_CNT_W'(MAX_FRAME_LEN));

   assign push_valid      = a_valid_ff && (a_finish_ff || close);
   assign push_rec.finish = a_finish_ff;
   assign push_rec.signal = s_in;
   assign push_rec.error  = n_in;
   assign push_rec.count  = cnt_in;

   assign advance   = a_valid_ff && (!push_valid || push_ready);
   assign req_stall = a_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         a_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         a_finish_ff <= (req_opcode == OP_FINISH);
         a_fe_ff     <= req_frame_end;
         sq_s_ff     <= cc[30:0];
         sq_e_ff     <= dd[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_acc_ff <= '0;
         n_acc_ff <= '0;
         cnt_ff   <= '0;
      end else if (advance && !a_finish_ff) begin
         if (close) begin
            s_acc_ff <= '0;
            n_acc_ff <= '0;
            cnt_ff   <= '0;
         end else begin
            s_acc_ff <= s_in;
            n_acc_ff <= n_in;
            cnt_ff   <= cnt_in;
         end
      end
   end

endmodule

FILE: hw/rtl/ssm_fifo.sv
// Short record queue between the front end and the back end.
`timescale 1ns / 1ps
module ssm_fifo
   import ssm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  frame_rec_type push_rec,
   output logic          push_ready,
   output logic          pop_valid,
   output frame_rec_type pop_rec,
   input  logic          pop
);

   frame_rec_type         mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_rec    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!do_push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

FILE: hw/rtl/ssm_log_unit.sv
// Iterative log2 in Q16: leading-one search by shifting, then a table lookup of the fraction.
`timescale 1ns / 1ps
module ssm_log_unit
   import ssm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [TOTAL_W-1:0] value,
   output logic               done,
   output logic [LOG_W-1:0]   result
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [TOTAL_W-1:0]   val_ff;
   logic [LOG_EXP_W-1:0] shift_ff;
   logic [LOG_W-1:0]     result_ff;

   assign done   = done_ff;
   assign result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (val_ff[TOTAL_W-1] || val_ff == '0)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         val_ff   <= value;
         shift_ff <= '0;
      end else if (busy_ff) begin
         if (val_ff[TOTAL_W-1] || val_ff == '0) begin
            result_ff <= {~shift_ff, LOG_TABLE[val_ff[TOTAL_W-2 -: LOG_IDX_W]]};
         end else if (val_ff[TOTAL_W-1 -: 8] == '0) begin
            val_ff   <= val_ff << 8;
            shift_ff <= shift_ff + LOG_EXP_W'(8);
         end else begin
            val_ff   <= val_ff << 1;
            shift_ff <= shift_ff + 1'b1;
         end
      end
   end

endmodule

FILE: hw/rtl/ssm_back.sv
// Back end: frame threshold test, segment SNR, global totals, finish division and result word.
`timescale 1ns / 1ps
module ssm_back
   import ssm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [THRESH_W-1:0] energy_threshold,
   input  logic [CAP_W-1:0]    lossless_snr_cap,
   input  logic                fifo_valid,
   input  frame_rec_type       fifo_rec,
   output logic                fifo_pop,
   output logic                log_start,
   output logic [TOTAL_W-1:0]  log_value,
   input  logic                log_done,
   input  logic [LOG_W-1:0]    log_result,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SNR_W-1:0]    rsp_avg_segment_snr,
   output logic [SNR_W-1:0]    rsp_global_snr,
   output logic [TALLY_W-1:0]  rsp_counted_frames,
   output logic [TALLY_W-1:0]  rsp_total_frames
);

   back_state_type state_ff, state_in;

   logic                   w_finish_ff;
   logic [TOTAL_W-1:0]     w_s_ff;
   logic [TOTAL_W-1:0]     w_n_ff;
   logic [FRAME_CNT_W-1:0] w_cnt_ff;
   logic [THR_PROD_W-1:0]  thr_prod_ff;
   logic [LOG_W-1:0]       log_s_ff;
   logic [LOG_W-1:0]       mag_ff;
   logic                   neg_ff;
   logic [DB_PROD_W-1:0]   mul_ff;
   logic [SNR_W-1:0]       avg_ff;
   logic [SNR_W-1:0]       glob_ff;
   logic [TOTAL_W-1:0]     total_s_ff;
   logic [TOTAL_W-1:0]     total_n_ff;
   logic [SEG_SUM_W-1:0]   seg_sum_ff;
   logic [TALLY_W-1:0]     counted_ff;
   logic [TALLY_W-1:0]     frames_ff;
   logic [DIV_STEPS-1:0]   num_ff;
   logic [TALLY_W-1:0]     rem_ff;
   logic [DIV_CNT_W-1:0]   div_cnt_ff;
   logic                   div_neg_ff;
   logic                   rsp_valid_ff;
   logic [SNR_W-1:0]       rsp_avg_ff;
   logic [SNR_W-1:0]       rsp_glob_ff;
   logic [TALLY_W-1:0]     rsp_counted_ff;
   logic [TALLY_W-1:0]     rsp_frames_ff;

   logic                   rsp_open;
   logic                   above;
   logic signed [LOG_W:0]  log_diff;
   logic [DB_PROD_W:0]     round_sum;
   logic [SNR_W-1:0]       snr_mag;
   logic [SNR_W-1:0]       snr_val;
   logic [SEG_SUM_W-1:0]   seg_mag;
   logic [TALLY_W:0]       rem_t;
   logic                   rem_ge;
   logic [SNR_W-1:0]       avg_sat;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_avg_segment_snr = rsp_avg_ff;
   assign rsp_global_snr      = rsp_glob_ff;
   assign rsp_counted_frames  = rsp_counted_ff;
   assign rsp_total_frames    = rsp_frames_ff;

   assign rsp_open  = !rsp_valid_ff || !rsp_stall;
   assign above     = w_s_ff > TOTAL_W'(thr_prod_ff);
   assign log_diff  = $signed({1'b0, log_s_ff}) - $signed({1'b0, log_result});
   assign round_sum = (DB_PROD_W + 1)'(mul_ff) + ((DB_PROD_W + 1)'(1) << 24);
   assign snr_mag   = round_sum[25 +: SNR_W];
   assign snr_val   = neg_ff ? (~snr_mag + 1'b1) : snr_mag;
   assign seg_mag   = seg_sum_ff[SEG_SUM_W-1] ? (~seg_sum_ff + 1'b1) : seg_sum_ff;
   assign rem_t     = {rem_ff, num_ff[DIV_STEPS-1]};
   assign rem_ge    = rem_t >= {1'b0, counted_ff};

   always_comb begin
      if (!div_neg_ff) begin
         avg_sat = (num_ff > DIV_STEPS'(32767)) ? 16'sh7fff : num_ff[SNR_W-1:0];
      end else begin
         avg_sat = (num_ff > DIV_STEPS'(32768)) ? 16'sh8000
                                                : (~num_ff[SNR_W-1:0] + 1'b1);
      end
   end

   always_comb begin
      state_in  = state_ff;
      fifo_pop  = 1'b0;
      log_start = 1'b0;
      log_value = w_s_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (fifo_valid) begin
               fifo_pop = 1'b1;
               state_in = fifo_rec.finish ? B_FIN_CHECK : B_THRESH;
            end
         end
         B_THRESH: begin
            state_in = B_DECIDE;
         end
         B_DECIDE: begin
            if (above && w_n_ff != '0) begin
               log_start = 1'b1;
               state_in  = B_LOG_S;
            end else begin
               state_in = B_IDLE;
            end
         end
         B_LOG_S: begin
            if (log_done) begin
               log_start = 1'b1;
               log_value = w_n_ff;
               state_in  = B_LOG_N;
            end
         end
         B_LOG_N: begin
            if (log_done) begin
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            state_in = B_ROUND;
         end
         B_ROUND: begin
            state_in = w_finish_ff ? B_OUT : B_IDLE;
         end
         B_FIN_CHECK: begin
            if (w_s_ff == '0 || w_n_ff == '0) begin
               state_in = B_OUT;
            end else if (counted_ff != '0) begin
               state_in = B_DIV;
            end else begin
               log_start = 1'b1;
               state_in  = B_LOG_S;
            end
         end
         B_DIV: begin
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = B_AVG;
            end
         end
         B_AVG: begin
            log_start = 1'b1;
            state_in  = B_LOG_S;
         end
         B_OUT: begin
            if (rsp_open) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_s_ff   <= '0;
         total_n_ff   <= '0;
         seg_sum_ff   <= '0;
         counted_ff   <= '0;
         frames_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == B_OUT && rsp_open) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_THRESH: begin
               total_s_ff <= total_s_ff + w_s_ff;
               total_n_ff <= total_n_ff + w_n_ff;
               frames_ff  <= frames_ff + 1'b1;
            end
            B_DECIDE: begin
               if (above) begin
                  counted_ff <= counted_ff + 1'b1;
                  if (w_n_ff == '0) begin
                     seg_sum_ff <= seg_sum_ff + SEG_SUM_W'(lossless_snr_cap);
                  end
               end
            end
            B_ROUND: begin
               if (!w_finish_ff) begin
                  seg_sum_ff <= seg_sum_ff + {{(SEG_SUM_W-SNR_W){snr_val[SNR_W-1]}}, snr_val};
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            w_finish_ff <= fifo_rec.finish;
            w_cnt_ff    <= fifo_rec.count;
            if (fifo_rec.finish) begin
               w_s_ff <= total_s_ff;
               w_n_ff <= total_n_ff;
            end else begin
               w_s_ff <= TOTAL_W'(fifo_rec.signal);
               w_n_ff <= TOTAL_W'(fifo_rec.error);
            end
         end
         B_THRESH: begin
            thr_prod_ff <= THR_PROD_W'(energy_threshold) * THR_PROD_W'(w_cnt_ff);
         end
         B_LOG_S: begin
            if (log_done) begin
               log_s_ff <= log_result;
            end
         end
         B_LOG_N: begin
            neg_ff <= log_diff[LOG_W];
            mag_ff <= log_diff[LOG_W] ? LOG_W'(-log_diff) : log_diff[LOG_W-1:0];
         end
         B_MUL: begin
            mul_ff <= DB_PROD_W'(mag_ff) * DB_PROD_W'(DB_PER_LOG2_Q16);
         end
         B_ROUND: begin
            glob_ff <= snr_val;
         end
         B_FIN_CHECK: begin
            avg_ff     <= '0;
            glob_ff    <= '0;
            div_neg_ff <= seg_sum_ff[SEG_SUM_W-1];
            num_ff     <= DIV_STEPS'(seg_mag) + DIV_STEPS'(counted_ff >> 1);
            rem_ff     <= '0;
            div_cnt_ff <= '0;
         end
         B_DIV: begin
            rem_ff     <= rem_ge ? TALLY_W'(rem_t - {1'b0, counted_ff}) : rem_t[TALLY_W-1:0];
            num_ff     <= {num_ff[DIV_STEPS-2:0], rem_ge};
            div_cnt_ff <= div_cnt_ff + 1'b1;
         end
         B_AVG: begin
            avg_ff <= avg_sat;
         end
         B_OUT: begin
            if (rsp_open) begin
               rsp_avg_ff     <= avg_ff;
               rsp_glob_ff    <= glob_ff;
               rsp_counted_ff <= counted_ff;
               rsp_frames_ff  <= frames_ff;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: hw/rtl/segmental_snr_meter_top.sv
// Top level of the segmental SNR meter: configuration registers and block wiring.
`timescale 1ns / 1ps
// The front end takes one word per cycle: sample words are squared and summed
// into the open frame at full rate. Each closed frame and each finish word goes
// through a four-entry queue to the back end, which handles one record at a
// time. A frame below the threshold or with zero error energy passes only the
// threshold and decide states there; a counted frame adds two log2 runs on a
// shared shift unit, then the scaling and rounding states. A finish word with
// nonzero totals takes a bit-serial division when frames were counted, then
// the two log2 runs; every finish word then waits for the result register.
// Sample words stall only while the queue is full and a frame or finish word
// must be queued. SNR values are in 1/128 dB.
module segmental_snr_meter_top
   import ssm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [SAMPLE_W-1:0]   req_clean_sample,
   input  logic [SAMPLE_W-1:0]   req_processed_sample,
   input  logic                  req_frame_end,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SNR_W-1:0]      rsp_avg_segment_snr,
   output logic [SNR_W-1:0]      rsp_global_snr,
   output logic [TALLY_W-1:0]    rsp_counted_frames,
   output logic [TALLY_W-1:0]    rsp_total_frames
);

   logic [THRESH_W-1:0] energy_threshold_ff;
   logic [CAP_W-1:0]    lossless_snr_cap_ff;

   logic               push_valid;
   frame_rec_type      push_rec;
   logic               push_ready;
   logic               pop_valid;
   frame_rec_type      pop_rec;
   logic               pop;
   logic               log_start;
   logic [TOTAL_W-1:0] log_value;
   logic               log_done;
   logic [LOG_W-1:0]   log_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_threshold_ff <= ENERGY_THRESHOLD_RESET;
         lossless_snr_cap_ff <= LOSSLESS_SNR_CAP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENERGY_THRESHOLD: energy_threshold_ff <= csr_wdata[THRESH_W-1:0];
            CSR_LOSSLESS_SNR_CAP: lossless_snr_cap_ff <= csr_wdata[CAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   ssm_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_opcode           (req_opcode),
      .req_clean_sample     (req_clean_sample),
      .req_processed_sample (req_processed_sample),
      .req_frame_end        (req_frame_end),
      .push_valid           (push_valid),
      .push_rec             (push_rec),
      .push_ready           (push_ready)
   );

   ssm_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_rec   (push_rec),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_rec    (pop_rec),
      .pop        (pop)
   );

   ssm_log_unit u_log (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .value  (log_value),
      .done   (log_done),
      .result (log_result)
   );

   ssm_back u_back (
      .clock               (clock),
      .reset               (reset),
      .energy_threshold    (energy_threshold_ff),
      .lossless_snr_cap    (lossless_snr_cap_ff),
      .fifo_valid          (pop_valid),
      .fifo_rec            (pop_rec),
      .fifo_pop            (pop),
      .log_start           (log_start),
      .log_value           (log_value),
      .log_done            (log_done),
      .log_result          (log_result),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_avg_segment_snr (rsp_avg_segment_snr),
      .rsp_global_snr      (rsp_global_snr),
      .rsp_counted_frames  (rsp_counted_frames),
      .rsp_total_frames    (rsp_total_frames)
   );

endmodule

FILE: tb/ssm_checker.sv
// Checker for the segmental SNR meter: predicts each report and compares it with the block.
`timescale 1ns / 1ps
module ssm_checker
   import ssm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [SAMPLE_W-1:0]   req_clean_sample,
   input  logic [SAMPLE_W-1:0]   req_processed_sample,
   input  logic                  req_frame_end,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [SNR_W-1:0]      rsp_avg_segment_snr,
   input  logic [SNR_W-1:0]      rsp_global_snr,
   input  logic [TALLY_W-1:0]    rsp_counted_frames,
   input  logic [TALLY_W-1:0]    rsp_total_frames,
   output int                    failures,
   output int                    pending
);

   typedef struct {
      logic [SNR_W-1:0]   avg;
      logic [SNR_W-1:0]   glob;
      logic [TALLY_W-1:0] counted;
      logic [TALLY_W-1:0] total;
   } snr_report_type;

   snr_report_type         expected_reports[$];
   logic [LOG_FRAC_W-1:0]  frac_log [LOG_TABLE_ENTRIES];
   logic [THRESH_W-1:0]    thr;
   logic [CAP_W-1:0]       cap;
   logic [FRAME_ACC_W-1:0] fr_sig, fr_err;
   longint                 fr_cnt;
   logic [TOTAL_W-1:0]     tot_sig, tot_err;
   logic [SEG_SUM_W-1:0]   seg_sum;
   logic [TALLY_W-1:0]     counted_tally, frame_count;

   initial begin
      logic [63:0]           x;
      logic [LOG_FRAC_W-1:0] r;
      failures = 0;
      for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
         x = (64'(LOG_TABLE_ENTRIES + i) << 30) / 64'(LOG_TABLE_ENTRIES);
         r = '0;
         for (int k = 0; k < LOG_FRAC_W; k++) begin
            x = (x * x) >> 30;
            r = r << 1;
            if (x >= (64'd2 << 30)) begin
               r[0] = 1'b1;
               x = x >> 1;
            end
         end
         frac_log[i] = r;
      end
   end

   assign pending = expected_reports.size();

   function automatic longint log2_fixed(logic [63:0] v);
      int          e;
      logic [63:0] f;
      e = 63;
      while (e > 0 && !v[e]) e--;
      f = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
      return (longint'(e) << 16) + longint'({48'd0, frac_log[f[29:24]]});
   endfunction

   function automatic longint snr_db(logic [63:0] s, logic [63:0] n);
      longint      d, p, r;
      logic [63:0] m;
      d = log2_fixed(s) - log2_fixed(n);
      p = d * 197283 * 128;
      m = (p < 0) ? -p : p;
      r = longint'((m + (64'd1 << 31)) >> 32);
      return (p < 0) ? -r : r;
   endfunction

   function automatic logic [SNR_W-1:0] clamp_snr(longint v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   task automatic report_mismatch(string what, longint want, longint got);
      $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
      failures++;
   endtask

   task automatic close_frame();
      longint seg;
      if ({16'd0, fr_sig} > 64'(thr) * 64'(fr_cnt)) begin
         seg = (fr_err == 0) ? longint'(cap) : snr_db({16'd0, fr_sig}, {16'd0, fr_err});
         counted_tally++;
         seg_sum = seg_sum + seg[SEG_SUM_W-1:0];
      end
      tot_sig += {16'd0, fr_sig};
      tot_err += {16'd0, fr_err};
      frame_count++;
      fr_sig = '0;
      fr_err = '0;
      fr_cnt = 0;
   endtask

   task automatic predict_word();
      longint         c, p, e, avg, glob, sum;
      logic [63:0]    m, q;
      snr_report_type rep;
      if (req_opcode == OP_SAMPLE) begin
         c = longint'($signed(req_clean_sample));
         p = longint'($signed(req_processed_sample));
         e = c - p;
         fr_sig = fr_sig + 48'(c * c);
         fr_err = fr_err + 48'(e * e);
         fr_cnt++;
         if (req_frame_end || fr_cnt >= MAX_FRAME_LEN) close_frame();
      end else begin
         avg = 0;
         glob = 0;
         if (tot_sig != 0 && tot_err != 0) begin
            if (counted_tally != 0) begin
               sum = longint'($signed(seg_sum));
               m = (sum < 0) ? -sum : sum;
               q = (m + 64'(counted_tally / 2)) / 64'(counted_tally);
               avg = (sum < 0) ? -longint'(q) : longint'(q);
            end
            glob = snr_db(tot_sig, tot_err);
         end
         rep.avg = clamp_snr(avg);
         rep.glob = clamp_snr(glob);
         rep.counted = counted_tally;
         rep.total = frame_count;
         expected_reports.push_back(rep);
      end
   endtask

   always @(posedge clock) begin
      snr_report_type rep;
      if (reset) begin
         thr = ENERGY_THRESHOLD_RESET;
         cap = LOSSLESS_SNR_CAP_RESET;
         fr_sig = '0;
         fr_err = '0;
         fr_cnt = 0;
         tot_sig = '0;
         tot_err = '0;
         seg_sum = '0;
         counted_tally = '0;
         frame_count = '0;
         expected_reports.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_ENERGY_THRESHOLD) thr = csr_wdata[THRESH_W-1:0];
            else if (csr_index == CSR_LOSSLESS_SNR_CAP) cap = csr_wdata[CAP_W-1:0];
         end
         if (req_valid && !req_stall) predict_word();
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $display("unexpected report word at %0t", $realtime);
               failures++;
            end else begin
               rep = expected_reports.pop_front();
               if (rsp_avg_segment_snr !== rep.avg)
                  report_mismatch("avg_segment_snr", $signed(rep.avg),
                                  $signed(rsp_avg_segment_snr));
               if (rsp_global_snr !== rep.glob)
                  report_mismatch("global_snr", $signed(rep.glob), $signed(rsp_global_snr));
               if (rsp_counted_frames !== rep.counted)
                  report_mismatch("counted_frames", rep.counted, rsp_counted_frames);
               if (rsp_total_frames !== rep.total)
                  report_mismatch("total_frames", rep.total, rsp_total_frames);
            end
         end
      end
   end

endmodule

FILE: tb/testbench.sv
// Top of the segmental SNR meter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
   import ssm_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 300;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_opcode = OP_SAMPLE;
   logic [SAMPLE_W-1:0]   req_clean_sample = '0;
   logic [SAMPLE_W-1:0]   req_processed_sample = '0;
   logic                  req_frame_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [SNR_W-1:0]      rsp_avg_segment_snr, rsp_global_snr;
   logic [TALLY_W-1:0]    rsp_counted_frames, rsp_total_frames;
   int                    failures, pending;
   int                    cycles = 0;
   bit                    quiet = 1'b0;
   bit                    long_hold = 1'b0;

   always #6 clock = ~clock;

   segmental_snr_meter_top uut (.*);

   ssm_checker u_checker (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (quiet || reset) begin
            rsp_stall = 1'b0;
         end else if (long_hold) begin
            rsp_stall = 1'b1;
            repeat (600) @(negedge clock);
            long_hold = 1'b0;
            rsp_stall = 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic send_word(logic op, logic [15:0] c, logic [15:0] p, logic fe);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_opcode = op;
      req_clean_sample = c;
      req_processed_sample = p;
      req_frame_end = fe;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic finish_word();
      send_word(OP_FINISH, 16'($urandom), 16'($urandom), 1'($urandom));
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // frame kinds: full scale with small noise, quiet, lossless, unrelated, heavy noise
   task automatic run_frames(int n_items, int max_len);
      int          sent, len, kind, noise;
      logic [15:0] c, p;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, max_len);
         kind = $urandom_range(0, 4);
         for (int j = 0; j < len; j++) begin
            if (kind == 1) c = 16'($signed($urandom_range(0, 30)) - 15);
            else c = 16'($urandom);
            noise = (kind == 4) ? $urandom_range(0, 8191) - 4096 : $urandom_range(0, 14) - 7;
            case (kind)
               2: p = c;
               3: p = 16'($urandom);
               default: p = c + 16'(noise);
            endcase
            send_word(OP_SAMPLE, c, p, j == len - 1);
            sent++;
            if ($urandom_range(0, 40) == 0) begin
               finish_word();
               sent++;
            end
         end
      end
      finish_word();
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset = 1'b0;

      finish_word();
      send_word(OP_SAMPLE, 16'd1, 16'd0, 1'b1);
      send_word(OP_SAMPLE, 16'd3, 16'd1, 1'b1);
      finish_word();
      send_word(OP_SAMPLE, 16'h7fff, 16'h7fff, 1'b1);
      send_word(OP_SAMPLE, 16'h8000, 16'h7fff, 1'b0);
      send_word(OP_SAMPLE, 16'h0000, 16'h0000, 1'b1);
      send_word(OP_SAMPLE, 16'h8000, 16'h8000, 1'b1);
      send_word(OP_SAMPLE, 16'h7fff, 16'h8000, 1'b1);
      send_word(OP_SAMPLE, 16'd100, 16'd90, 1'b0);
      finish_word();
      send_word(OP_SAMPLE, 16'd5, 16'hfffb, 1'b1);
      send_word(OP_SAMPLE, 16'hffff, 16'h0001, 1'b1);
      finish_word();
      settle();

      write_csr(CSR_ENERGY_THRESHOLD, 31'd0);
      write_csr(CSR_LOSSLESS_SNR_CAP, 31'd0);
      run_frames(250, 12);
      settle();

      write_csr(CSR_ENERGY_THRESHOLD, 31'd1073741824);
      write_csr(CSR_LOSSLESS_SNR_CAP, 31'd32767);
      run_frames(200, 12);
      settle();

      write_csr(CSR_ENERGY_THRESHOLD, 31'd50);
      write_csr(CSR_LOSSLESS_SNR_CAP, 31'd16640);
      long_hold = 1'b1;
      run_frames(300, 2);
      settle();

      write_csr(CSR_ENERGY_THRESHOLD, 31'($urandom_range(0, 200000)));
      write_csr(CSR_LOSSLESS_SNR_CAP, 31'($urandom_range(0, 32767)));
      run_frames(500, 16);
      settle();

      write_csr(CSR_ENERGY_THRESHOLD, 31'h7fffffff);
      write_csr(CSR_LOSSLESS_SNR_CAP, 31'($urandom_range(0, 32767)));
      run_frames(150, 10);
      settle();

      write_csr(CSR_ENERGY_THRESHOLD, 31'd1000);
      write_csr(CSR_LOSSLESS_SNR_CAP, 31'd5000);
      quiet = 1'b1;
      run_frames(480, 12);
      settle();

      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/ssm_pkg.sv
hw/rtl/ssm_front.sv
hw/rtl/ssm_fifo.sv
hw/rtl/ssm_log_unit.sv
hw/rtl/ssm_back.sv
hw/rtl/segmental_snr_meter_top.sv
tb/ssm_checker.sv
tb/testbench.sv
